FILE: src/mi_pkg.sv
package mi_pkg;

	localparam logic OP_GIVEN = 1'b0;
	localparam logic OP_POW2  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TEST,
		ST_ALIGN,
		ST_SUB,
		ST_NEXT,
		ST_DONE
	} mi_state_t;

	typedef enum logic {
		MODE_ALIGN,
		MODE_SUB
	} mi_mode_t;

endpackage

FILE: src/mi_if.sv
interface mi_in_if #(parameter int WORD_BITS = 32);
	logic                 valid;
	logic                 ready;
	logic                 opcode;
	logic [WORD_BITS-1:0] value;
	logic [WORD_BITS-1:0] modulus;

	modport source (output valid, output opcode, output value, output modulus, input ready);
	modport sink   (input valid, input opcode, input value, input modulus, output ready);
endinterface

interface mi_out_if #(parameter int WORD_BITS = 32);
	logic                 valid;
	logic                 ready;
	logic [WORD_BITS-1:0] inverse;
	logic                 valid_res;

	modport source (output valid, output inverse, output valid_res, input ready);
	modport sink   (input valid, input inverse, input valid_res, output ready);
endinterface

FILE: src/modular_inverse_unit.sv
// Modular inverse by Euclid's algorithm with continuants. A transfer on in_ch carries
// opcode, value and modulus; opcode OP_GIVEN inverts modulo the given modulus, OP_POW2
// modulo 2^WORD_BITS. One result per item on out_ch: the inverse in 0 .. modulus-1 with
// valid_res 1, or zero with valid_res 0 when the value is zero, not below the modulus
// under OP_GIVEN, even under OP_POW2, or shares a factor with the modulus. One item at a
// time: in_ch is ready only between items. Each quotient step runs on one shared
// compare-subtract unit, one quotient bit per cycle. An item flagged at once goes from
// ST_IDLE straight to ST_DONE. in_ch is ready again as the result appears.
module modular_inverse_unit #(
	parameter int WORD_BITS = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	mi_in_if.sink    in_ch,
	mi_out_if.source out_ch
);
	import mi_pkg::*;

	mi_state_t state_q;
	mi_state_t state_nxt;

	logic                 op_q;
	logic                 ok_q;
	logic                 parity_q;
	logic [WORD_BITS-1:0] modulus_q;
	logic [WORD_BITS:0]   r0_q;
	logic [WORD_BITS-1:0] r1_q;
	logic [WORD_BITS:0]   d_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] ps1_q;
	logic [WORD_BITS-1:0] ps2_q;

	logic                 out_valid_q;
	logic [WORD_BITS-1:0] inverse_q;
	logic                 valid_res_q;

	mi_mode_t             mode;
	logic                 hit;
	logic [WORD_BITS:0]   rem_nxt;
	logic [WORD_BITS-1:0] acc_nxt;

	logic                 accept;
	logic                 in_ok;
	logic                 load_out;
	logic                 good;
	logic [WORD_BITS-1:0] neg;
	logic [WORD_BITS-1:0] inv_raw;
	logic [WORD_BITS-1:0] inv;

	assign mode = (state_q == ST_ALIGN) ? MODE_ALIGN : MODE_SUB;

	mi_step_unit #(.WORD_BITS(WORD_BITS)) u_step (
		.mode    (mode),
		.rem     (r0_q),
		.div     (d_q),
		.acc     (acc_q),
		.ps1     (ps1_q),
		.hit     (hit),
		.rem_nxt (rem_nxt),
		.acc_nxt (acc_nxt)
	);

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;

	always_comb begin
		in_ok = (in_ch.value != '0);
		if (in_ch.opcode == OP_GIVEN) begin
			in_ok = in_ok && (in_ch.value < in_ch.modulus);
		end else begin
			in_ok = in_ok && in_ch.value[0];
		end
	end

	always_comb begin
		if (op_q == OP_GIVEN) begin
			neg = modulus_q - ps1_q;
		end else begin
			neg = '0 - ps1_q;
		end
		inv_raw = parity_q ? neg : ps1_q;
		if (op_q == OP_GIVEN && inv_raw >= modulus_q) begin
			inv = '0;
		end else begin
			inv = inv_raw;
		end
		good = ok_q && (r1_q == {{(WORD_BITS-1){1'b0}}, 1'b1});
	end

	assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nxt = in_ok ? ST_TEST : ST_DONE;
				end
			end
			ST_TEST: begin
				if (r1_q > {{(WORD_BITS-1){1'b0}}, 1'b1}) begin
					state_nxt = ST_ALIGN;
				end else begin
					state_nxt = ST_DONE;
				end
			end
			ST_ALIGN: begin
				if (!hit) begin
					state_nxt = ST_SUB;
				end
			end
			ST_SUB: begin
				if (d_q == {1'b0, r1_q}) begin
					state_nxt = ST_NEXT;
				end
			end
			ST_NEXT: state_nxt = ST_TEST;
			ST_DONE: begin
				if (load_out) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q      <= in_ch.opcode;
					ok_q      <= in_ok;
					modulus_q <= in_ch.modulus;
					r1_q      <= in_ch.value;
					ps1_q     <= {{(WORD_BITS-1){1'b0}}, 1'b1};
					ps2_q     <= '0;
					parity_q  <= 1'b0;
					if (in_ch.opcode == OP_POW2) begin
						r0_q <= {1'b1, {WORD_BITS{1'b0}}};
					end else begin
						r0_q <= {1'b0, in_ch.modulus};
					end
				end
			end
			ST_TEST: begin
				d_q   <= {1'b0, r1_q};
				acc_q <= '0;
			end
			ST_ALIGN: begin
				if (hit) begin
					d_q <= {d_q[WORD_BITS-1:0], 1'b0};
				end
			end
			ST_SUB: begin
				if (hit) begin
					r0_q <= rem_nxt;
				end
				acc_q <= acc_nxt;
				d_q   <= {1'b0, d_q[WORD_BITS:1]};
			end
			ST_NEXT: begin
				ps1_q    <= acc_q + ps2_q;
				ps2_q    <= ps1_q;
				parity_q <= ~parity_q;
				r0_q     <= {1'b0, r1_q};
				r1_q     <= r0_q[WORD_BITS-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			inverse_q   <= good ? inv : '0;
			valid_res_q <= good;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.inverse   = inverse_q;
	assign out_ch.valid_res = valid_res_q;

endmodule

FILE: src/mi_step_unit.sv
module mi_step_unit #(
	parameter int WORD_BITS = 32
) (
	input  mi_pkg::mi_mode_t     mode,
	input  logic [WORD_BITS:0]   rem,
	input  logic [WORD_BITS:0]   div,
	input  logic [WORD_BITS-1:0] acc,
	input  logic [WORD_BITS-1:0] ps1,
	output logic                 hit,
	output logic [WORD_BITS:0]   rem_nxt,
	output logic [WORD_BITS-1:0] acc_nxt
);
	import mi_pkg::*;

	logic [WORD_BITS+1:0] cmp_b;

	always_comb begin
		if (mode == MODE_ALIGN) begin
			cmp_b = {div, 1'b0};
		end else begin
			cmp_b = {1'b0, div};
		end
		hit     = ({1'b0, rem} >= cmp_b);
		rem_nxt = rem - div;
		acc_nxt = {acc[WORD_BITS-2:0], 1'b0} + (hit ? ps1 : {WORD_BITS{1'b0}});
	end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import mi_pkg::*;

	localparam int WB = 32;
	localparam logic [63:0] WORD_SPAN = 64'd1 << WB;
	localparam logic [63:0] WORD_MASK = WORD_SPAN - 64'd1;
	localparam int RANDOM_ITEMS = 1030;
	localparam int MAX_GAP = 14;
	localparam int TAIL_CYCLES = 300;
	localparam int CYCLE_LIMIT = 1_200_000;

	typedef struct packed {
		logic          opcode;
		logic [WB-1:0] value;
		logic [WB-1:0] modulus;
	} inv_req_t;

	typedef struct packed {
		logic [WB-1:0] inverse;
		logic          valid_res;
	} inv_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mi_in_if  #(.WORD_BITS(WB)) in_ch ();
	mi_out_if #(.WORD_BITS(WB)) out_ch ();

	modular_inverse_unit #(.WORD_BITS(WB)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	inv_req_t inv_requests[$];
	inv_res_t inv_due[$];
	int       mismatches = 0;
	int       send_gap;
	int       take_gap;
	int       cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic inv_res_t predict_inverse(input logic op, input logic [WB-1:0] v,
			input logic [WB-1:0] m);
		logic [63:0] a, p, dvd, dvs, quo, rem, nxt, cont1, cont2, span_rest, inv;
		logic        odd_steps, ok;
		inv_res_t    res;
		a = v;
		p = m;
		ok = 1'b1;
		odd_steps = 1'b0;
		cont1 = 64'd1;
		cont2 = 64'd0;
		dvs = 64'd1;
		inv = 64'd0;
		if (a == 64'd0)
			ok = 1'b0;
		else if (op == OP_GIVEN && a >= p)
			ok = 1'b0;
		else if (op == OP_POW2 && !a[0])
			ok = 1'b0;
		if (ok && a > 64'd1) begin
			if (op == OP_GIVEN) begin
				dvd = p;
				dvs = a;
			end else begin
				span_rest = WORD_SPAN - a;
				dvd = a;
				dvs = span_rest % a;
				cont1 = (span_rest / a + 64'd1) & WORD_MASK;
				cont2 = 64'd1;
				odd_steps = 1'b1;
			end
			while (dvs > 64'd1) begin
				quo = dvd / dvs;
				rem = dvd % dvs;
				nxt = (quo * cont1 + cont2) & WORD_MASK;
				odd_steps = !odd_steps;
				dvd = dvs;
				dvs = rem;
				cont2 = cont1;
				cont1 = nxt;
			end
			if (dvs != 64'd1)
				ok = 1'b0;
		end
		if (ok) begin
			if (!odd_steps)
				inv = cont1 & WORD_MASK;
			else if (op == OP_GIVEN)
				inv = (p - cont1) & WORD_MASK;
			else
				inv = (WORD_SPAN - cont1) & WORD_MASK;
			if (op == OP_GIVEN && inv >= p)
				inv = 64'd0;
		end
		res.inverse = ok ? inv[WB-1:0] : '0;
		res.valid_res = ok;
		return res;
	endfunction

	task automatic add_req(input logic op, input logic [WB-1:0] v, input logic [WB-1:0] m);
		inv_req_t req;
		req.opcode = op;
		req.value = v;
		req.modulus = m;
		inv_requests.push_back(req);
	endtask

	function automatic inv_req_t random_req();
		inv_req_t req;
		int       pick;
		int       g;
		pick = $urandom_range(0, 19);
		req.opcode = OP_GIVEN;
		req.value = $urandom;
		req.modulus = $urandom;
		if (pick < 8) begin
			if (pick < 2)
				req.modulus = $urandom_range(2, 300);
			else if (pick == 2)
				req.modulus = req.modulus | 32'h8000_0000;
			if (req.modulus < 2)
				req.modulus = 2;
			req.value = 1 + ($urandom % (req.modulus - 1));
			if (pick == 3) begin
				req.modulus = req.modulus | 32'h10;
				req.value = req.modulus - $urandom_range(1, 4);
			end
		end else if (pick < 14) begin
			req.opcode = OP_POW2;
			req.value = req.value | 32'h1;
			if (pick == 8)
				req.value = $urandom_range(0, 7) | 32'h1;
		end else if (pick < 16) begin
			g = $urandom_range(2, 1000);
			req.value = g * $urandom_range(1, 1 << 20);
			req.modulus = g * $urandom_range(1, 1 << 21);
		end else begin
			req.opcode = 1'($urandom_range(0, 1));
			if (pick == 19)
				req.value = $urandom_range(0, 3);
		end
		return req;
	endfunction

	always @(posedge clk or negedge arst_n) begin : feed
		int       g;
		bit       calm;
		inv_req_t req;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.opcode <= OP_GIVEN;
			in_ch.value <= '0;
			in_ch.modulus <= '0;
			send_gap <= 0;
		end else begin
			g = send_gap;
			if (in_ch.valid && in_ch.ready) begin
				inv_due.push_back(predict_inverse(in_ch.opcode, in_ch.value, in_ch.modulus));
				if ($urandom_range(0, 39) == 0)
					calm = !calm;
				g = calm ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (g == 0 && inv_requests.size() > 0) begin
					req = inv_requests.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.opcode <= req.opcode;
					in_ch.value <= req.value;
					in_ch.modulus <= req.modulus;
				end else begin
					in_ch.valid <= 1'b0;
					if (g > 0)
						g = g - 1;
				end
			end
			send_gap <= g;
		end
	end

	always @(posedge clk or negedge arst_n) begin : take
		int       g;
		bit       calm;
		inv_res_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			take_gap <= 0;
		end else begin
			g = take_gap;
			if (out_ch.valid && out_ch.ready) begin
				if (inv_due.size() == 0) begin
					$display("%0t: unexpected transfer: inverse %h valid_res %b", $time,
						out_ch.inverse, out_ch.valid_res);
					mismatches++;
				end else begin
					want = inv_due.pop_front();
					if (out_ch.inverse !== want.inverse) begin
						$display("%0t: inverse expected %h actual %h", $time, want.inverse,
							out_ch.inverse);
						mismatches++;
					end
					if (out_ch.valid_res !== want.valid_res) begin
						$display("%0t: valid_res expected %b actual %b", $time, want.valid_res,
							out_ch.valid_res);
						mismatches++;
					end
				end
				if ($urandom_range(0, 39) == 0)
					calm = !calm;
				g = calm ? 0 : $urandom_range(0, MAX_GAP);
				out_ch.ready <= (g == 0);
			end else if (!out_ch.ready) begin
				if (g > 0)
					g = g - 1;
				out_ch.ready <= (g == 0);
			end
			take_gap <= g;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		add_req(OP_GIVEN, 32'd0, 32'd17);
		add_req(OP_POW2, 32'd0, 32'd5);
		add_req(OP_GIVEN, 32'd1, 32'd2);
		add_req(OP_POW2, 32'd1, 32'd0);
		add_req(OP_GIVEN, 32'd5, 32'd5);
		add_req(OP_GIVEN, 32'd7, 32'd3);
		add_req(OP_GIVEN, 32'd1, 32'd1);
		add_req(OP_GIVEN, 32'd1, 32'd0);
		add_req(OP_GIVEN, 32'd0, 32'd0);
		add_req(OP_POW2, 32'd2, 32'd7);
		add_req(OP_POW2, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
		add_req(OP_POW2, 32'hFFFF_FFFF, 32'd0);
		add_req(OP_POW2, 32'hAAAA_AAAB, 32'hFFFF_FFFF);
		add_req(OP_POW2, 32'd3, 32'd5);
		add_req(OP_GIVEN, 32'd6, 32'd9);
		add_req(OP_GIVEN, 32'd3, 32'hFFFF_FFFF);
		add_req(OP_GIVEN, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
		add_req(OP_GIVEN, 32'd1836311903, 32'd2971215073);
		add_req(OP_GIVEN, 32'd2, 32'd3);
		add_req(OP_GIVEN, 32'h7FFF_FFFF, 32'h8000_0000);
		add_req(OP_GIVEN, 32'h8000_0000, 32'hFFFF_FFFF);
		add_req(OP_GIVEN, 32'd12345, 32'd4294967291);
		repeat (RANDOM_ITEMS)
			inv_requests.push_back(random_req());

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		while (inv_requests.size() > 0 || in_ch.valid || inv_due.size() > 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
